FILE: sv/dot_star_pattern_matcher_macros.svh
// Assertion macros shared by the dot-star pattern matcher RTL.
`ifndef DOT_STAR_PATTERN_MATCHER_MACROS_SVH
`define DOT_STAR_PATTERN_MATCHER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/dsm_pkg.sv
// Package: constants, types and register codes of the dot-star pattern matcher.
package dsm_pkg;

  // Token slots held in the pattern registers, and the supported pattern length
  localparam int TOKEN_SLOTS = 16;
  localparam int PAT_LEN     = 16;
  localparam int LEN_CAP     = (PAT_LEN < TOKEN_SLOTS) ? PAT_LEN : TOKEN_SLOTS;

  // Position vector: bit k set means the first k tokens are matched
  localparam int POS_W = TOKEN_SLOTS + 1;
  localparam int LEN_W = 5;
  localparam int CHR_W = 8;

  // Configuration port
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHARS_LO  = 3'd0,
    REG_CHARS_HI  = 3'd1,
    REG_DOT_MASK  = 3'd2,
    REG_STAR_MASK = 3'd3,
    REG_PAT_LEN   = 3'd4
  } cfg_reg_t;

  typedef logic [POS_W-1:0] pos_vec_t;

  // Active pattern as seen by the datapath; len is already clamped
  typedef struct packed {
    logic [TOKEN_SLOTS*CHR_W-1:0] chars;
    logic [TOKEN_SLOTS-1:0]       dot;
    logic [TOKEN_SLOTS-1:0]       star;
    logic [LEN_W-1:0]             len;
  } pattern_t;

endpackage

FILE: sv/dsm_if.sv
// Handshake channels of the matcher: subject bytes in, match results out.
interface dsm_in_if;
  import dsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [CHR_W-1:0] ch;
  logic             last;
  logic             end_only;

  modport source (output valid, output ch, output last, output end_only, input ready);
  modport sink   (input valid, input ch, input last, input end_only, output ready);
endinterface

interface dsm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

FILE: sv/dot_star_pattern_matcher.sv
// Dot-star pattern matcher: one subject byte per cycle, one result per string.
// Throughput: one beat per cycle, set by the single NFA update (closure, byte
// compare, closure) between input and result register; an ending beat waits in
// the input register until the result register is free, then loads the result.
// Reset (synchronous): pattern registers clear to the empty pattern, only
// position zero is active, and both the input and output stages are empty.
`include "dot_star_pattern_matcher_macros.svh"

module dot_star_pattern_matcher (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  dsm_in_if.sink                           item,
  dsm_out_if.source                        result
);
  import dsm_pkg::*;

  pattern_t         pat;

  // Input stage
  logic             s1_valid;
  logic [CHR_W-1:0] s1_ch;
  logic             s1_last;
  logic             s1_end_only;

  // NFA state and output stage
  pos_vec_t         active;
  logic             out_valid;
  logic             out_matched;

  pos_vec_t         set_start;
  pos_vec_t         set_byte;
  pos_vec_t         set_after;
  pos_vec_t         set_fin;
  logic             s1_ends;
  logic             out_free;
  logic             s1_adv;

  dsm_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pat       (pat)
  );

  dsm_closure u_close_start (
    .pat     (pat),
    .set_in  (active),
    .set_out (set_start)
  );

  dsm_advance u_advance (
    .pat     (pat),
    .set_in  (set_start),
    .ch      (s1_ch),
    .set_out (set_byte)
  );

  dsm_closure u_close_byte (
    .pat     (pat),
    .set_in  (set_byte),
    .set_out (set_after)
  );

  // Pick the final set and the handshake between stages
  always_comb begin
    set_fin  = s1_end_only ? set_start : set_after;
    s1_ends  = s1_last || s1_end_only;
    out_free = !out_valid || result.ready;
    s1_adv   = s1_valid && (!s1_ends || out_free);
  end

  assign item.ready     = !s1_valid || s1_adv;
  assign result.valid   = out_valid;
  assign result.matched = out_matched;

  // Input register: load on accept, drop when the beat moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.valid && item.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item.valid && item.ready) begin
      s1_ch       <= item.ch;
      s1_last     <= item.last;
      s1_end_only <= item.end_only;
    end
  end

  // Advance the active set; restart at position zero when a string ends
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= POS_W'(1);
    end else if (s1_adv) begin
      active <= s1_ends ? POS_W'(1) : set_fin;
    end
  end

  // Result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_ends) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_ends) begin
      out_matched <= set_fin[pat.len];
    end
  end

  // Checks
  `DSM_ASSERT_NEXT(a_restart, clk, rst, s1_adv && s1_ends, active == POS_W'(1), "NFA not restarted after string end")
  `DSM_ASSERT_NOW(a_res_src, clk, rst, $rose(out_valid), $past(s1_valid && s1_ends), "result without an ending beat")
  `DSM_ASSERT_NEXT(a_s1_hold, clk, rst, s1_valid && s1_ends && out_valid && !result.ready, s1_valid, "ending beat lost while output stalled")

endmodule

FILE: sv/dsm_cfg_regs.sv
// Pattern configuration registers with length clamping.
module dsm_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [dsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dsm_pkg::CFG_DATA_W-1:0]   cfg_data,
  output dsm_pkg::pattern_t                pat
);
  import dsm_pkg::*;

  logic [CFG_DATA_W-1:0]  chars_lo;
  logic [CFG_DATA_W-1:0]  chars_hi;
  logic [TOKEN_SLOTS-1:0] dot_mask;
  logic [TOKEN_SLOTS-1:0] star_mask;
  logic [LEN_W-1:0]       pat_len;

  // Write one register per beat; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      chars_lo  <= '0;
      chars_hi  <= '0;
      dot_mask  <= '0;
      star_mask <= '0;
      pat_len   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_CHARS_LO:  chars_lo  <= cfg_data;
        REG_CHARS_HI:  chars_hi  <= cfg_data;
        REG_DOT_MASK:  dot_mask  <= cfg_data[TOKEN_SLOTS-1:0];
        REG_STAR_MASK: star_mask <= cfg_data[TOKEN_SLOTS-1:0];
        REG_PAT_LEN:   pat_len   <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the length to the token slots that exist
  always_comb begin
    pat.chars = {chars_hi, chars_lo};
    pat.dot   = dot_mask;
    pat.star  = star_mask;
    pat.len   = (pat_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : pat_len;
  end

endmodule

FILE: sv/dsm_closure.sv
// Star-skip closure: mask positions to the pattern length, then let starred
// tokens be skipped, as a parallel-prefix over the position vector.
module dsm_closure (
  input  dsm_pkg::pattern_t pat,
  input  dsm_pkg::pos_vec_t set_in,
  output dsm_pkg::pos_vec_t set_out
);
  import dsm_pkg::*;

  localparam int LEVELS = $clog2(POS_W);

  pos_vec_t gen [0:LEVELS];
  pos_vec_t prp [0:LEVELS];

  // Seed: live positions up to len; position i inherits from i-1 when
  // token i-1 is starred and in use
  always_comb begin
    for (int i = 0; i < POS_W; i++) begin
      gen[0][i] = set_in[i] && (LEN_W'(i) <= pat.len);
      if (i == 0) begin
        prp[0][i] = 1'b0;
      end else begin
        prp[0][i] = pat.star[i-1] && (LEN_W'(i-1) < pat.len);
      end
    end
    // Combine spans of doubling width
    for (int l = 0; l < LEVELS; l++) begin
      for (int i = 0; i < POS_W; i++) begin
        if (i >= (1 << l)) begin
          gen[l+1][i] = gen[l][i] | (prp[l][i] & gen[l][i-(1<<l)]);
          prp[l+1][i] = prp[l][i] & prp[l][i-(1<<l)];
        end else begin
          gen[l+1][i] = gen[l][i];
          prp[l+1][i] = prp[l][i];
        end
      end
    end
  end

  assign set_out = gen[LEVELS];

endmodule

FILE: sv/dsm_advance.sv
// Byte step of the NFA: each live token that accepts the byte either stays
// (starred) or moves one position on.
module dsm_advance (
  input  dsm_pkg::pattern_t             pat,
  input  dsm_pkg::pos_vec_t             set_in,
  input  logic [dsm_pkg::CHR_W-1:0]     ch,
  output dsm_pkg::pos_vec_t             set_out
);
  import dsm_pkg::*;

  logic [TOKEN_SLOTS-1:0] hit;
  logic [TOKEN_SLOTS-1:0] stay;
  logic [TOKEN_SLOTS-1:0] step;

  // Compare every token against the byte in parallel
  always_comb begin
    for (int k = 0; k < TOKEN_SLOTS; k++) begin
      hit[k] = set_in[k] && (LEN_W'(k) < pat.len) &&
               (pat.dot[k] || (pat.chars[k*CHR_W +: CHR_W] == ch));
    end
    stay = hit & pat.star;
    step = hit & ~pat.star;
  end

  assign set_out = {1'b0, stay} | {step, 1'b0};

endmodule

FILE: dv/tb_dot_star_pattern_matcher.sv
// Testbench for the dot-star pattern matcher: directed and random strings checked by a local NFA.
`timescale 1ns / 100ps

module tb_dot_star_pattern_matcher;
  import dsm_pkg::*;

  localparam logic [7:0] DOT_BYTE = 8'h2E;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  dsm_in_if  item_if ();
  dsm_out_if result_if ();

  dot_star_pattern_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_if),
    .result    (result_if)
  );

  // Local copy of the pattern registers and the NFA position vector
  logic [63:0]            chars_lo_m;
  logic [63:0]            chars_hi_m;
  logic [TOKEN_SLOTS-1:0] dot_m;
  logic [TOKEN_SLOTS-1:0] star_m;
  logic [LEN_W-1:0]       len_m;
  pos_vec_t               nfa_active;

  logic        expected_matches[$];
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned in_idle_pct;
  int unsigned out_stall_pct;

  always #6 clk = ~clk;

  // Clamp the length register to the token slots that exist
  function automatic int unsigned used_tokens();
    return (len_m > LEN_CAP) ? LEN_CAP : int'(len_m);
  endfunction

  // Drop positions past the pattern end, then let starred tokens be skipped
  function automatic pos_vec_t star_closure(pos_vec_t set, int unsigned n);
    pos_vec_t s;
    s = set;
    for (int k = 0; k < POS_W; k++)
      if (k > n) s[k] = 1'b0;
    for (int k = 0; k < n; k++)
      if (s[k] && star_m[k]) s[k+1] = 1'b1;
    return s;
  endfunction

  // Advance every active position whose token accepts the byte
  function automatic pos_vec_t consume_byte(pos_vec_t set, int unsigned n, logic [7:0] c);
    logic [TOKEN_SLOTS*8-1:0] toks;
    pos_vec_t                 nxt;
    toks = {chars_hi_m, chars_lo_m};
    nxt  = '0;
    for (int k = 0; k < n; k++) begin
      if (set[k] && (dot_m[k] || toks[8*k +: 8] == c)) begin
        if (star_m[k]) nxt[k] = 1'b1;
        else nxt[k+1] = 1'b1;
      end
    end
    return nxt;
  endfunction

  // Predict on every accepted input beat
  always @(posedge clk) begin
    pos_vec_t    set;
    int unsigned n;
    if (!rst && item_if.valid && item_if.ready) begin
      n   = used_tokens();
      set = star_closure(nfa_active, n);
      if (!item_if.end_only) set = star_closure(consume_byte(set, n, item_if.ch), n);
      if (item_if.last || item_if.end_only) begin
        expected_matches.push_back(set[n]);
        nfa_active = pos_vec_t'(1);
      end else begin
        nfa_active = set;
      end
    end
  end

  // Compare each result beat with the oldest prediction
  always @(posedge clk) begin
    logic exp_match;
    if (!rst && result_if.valid && result_if.ready) begin
      if (expected_matches.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual matched=%0b",
                 $time, result_if.matched);
        error_count++;
      end else begin
        exp_match = expected_matches.pop_front();
        if (result_if.matched !== exp_match) begin
          $display("%0t: matched mismatch, expected %0b, actual %0b",
                   $time, exp_match, result_if.matched);
          error_count++;
        end
      end
    end
  end

  // Stall the result side at the current rate
  always @(negedge clk) begin
    result_if.ready = (out_stall_pct == 0) || ($urandom_range(99) >= out_stall_pct);
  end

  // Send one input beat, with a random gap ahead of it
  task automatic send_char(input logic [7:0] c, input logic l, input logic e);
    @(negedge clk);
    while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
      item_if.valid = 1'b0;
      @(negedge clk);
    end
    item_if.valid    = 1'b1;
    item_if.ch       = c;
    item_if.last     = l;
    item_if.end_only = e;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    items_sent++;
  endtask

  // Drop valid, wait for all results, then let the input stage empty
  task automatic wait_drain();
    @(negedge clk);
    item_if.valid = 1'b0;
    while (expected_matches.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      REG_CHARS_LO:  chars_lo_m = data;
      REG_CHARS_HI:  chars_hi_m = data;
      REG_DOT_MASK:  dot_m      = data[TOKEN_SLOTS-1:0];
      REG_STAR_MASK: star_m     = data[TOKEN_SLOTS-1:0];
      REG_PAT_LEN:   len_m      = data[LEN_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                              input logic [15:0] dots, input logic [15:0] stars,
                              input logic [LEN_W-1:0] n);
    wait_drain();
    write_reg(REG_CHARS_LO, lo);
    write_reg(REG_CHARS_HI, hi);
    write_reg(REG_DOT_MASK, CFG_DATA_W'(dots));
    write_reg(REG_STAR_MASK, CFG_DATA_W'(stars));
    write_reg(REG_PAT_LEN, CFG_DATA_W'(n));
  endtask

  // Bias bytes toward a few values so literals collide often
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(5))
      0: return "a";
      1: return "b";
      2: return DOT_BYTE;
      3: return 8'h00;
      4: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic load_random_pattern();
    logic [TOKEN_SLOTS*8-1:0] toks;
    logic [15:0]              dots;
    logic [15:0]              stars;
    logic [LEN_W-1:0]         n;
    int unsigned              r;
    r = $urandom_range(9);
    if (r < 7) n = LEN_W'($urandom_range(0, 6));
    else if (r == 7) n = LEN_W'($urandom_range(7, 15));
    else if (r == 8) n = LEN_W'(16);
    else n = LEN_W'($urandom_range(17, 31));
    for (int k = 0; k < TOKEN_SLOTS; k++) begin
      toks[8*k +: 8] = pick_byte();
      dots[k]        = ($urandom_range(3) == 0);
      stars[k]       = ($urandom_range(2) == 0);
    end
    load_pattern(toks[63:0], toks[127:64], dots, stars, n);
  endtask

  // Build a string that fits the pattern, optionally break it, then send it
  task automatic send_string(input bit well_formed);
    logic [7:0]               bytes[$];
    logic [TOKEN_SLOTS*8-1:0] toks;
    int unsigned              n;
    int unsigned              reps;
    bit                       end_by_marker;
    n    = used_tokens();
    toks = {chars_hi_m, chars_lo_m};
    for (int k = 0; k < n; k++) begin
      reps = star_m[k] ? $urandom_range(0, 3) : 1;
      repeat (reps) bytes.push_back(dot_m[k] ? pick_byte() : toks[8*k +: 8]);
    end
    if (!well_formed) begin
      case ($urandom_range(3))
        0: if (bytes.size() > 0) bytes.delete($urandom_range(bytes.size() - 1));
        1: bytes.insert($urandom_range(bytes.size()), pick_byte());
        2: if (bytes.size() > 0) bytes[$urandom_range(bytes.size() - 1)] = pick_byte();
        default: begin
          bytes.delete();
          repeat ($urandom_range(0, 6)) bytes.push_back(pick_byte());
        end
      endcase
    end
    end_by_marker = (bytes.size() == 0) || ($urandom_range(3) == 0);
    for (int k = 0; k < bytes.size(); k++)
      send_char(bytes[k], !end_by_marker && (k == bytes.size() - 1), 1'b0);
    if (end_by_marker) send_char(8'($urandom_range(255)), 1'($urandom_range(1)), 1'b1);
  endtask

  // Reset pattern is empty: only the empty string matches
  task automatic test_empty_pattern();
    send_char(8'h5A, 1'b0, 1'b1);
    send_char(8'h00, 1'b1, 1'b0);
  endtask

  // Literal dot byte, zero byte, any-byte token and 0xFF
  task automatic test_literal_tokens();
    load_pattern(64'h0000_0000_FF7A_002E, 64'h0, 16'h0004, 16'h0000, 5'd4);
    send_char(DOT_BYTE, 1'b0, 1'b0);
    send_char(8'h00, 1'b0, 1'b0);
    send_char(8'h41, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char("x", 1'b1, 1'b0);
  endtask

  task automatic test_star_tokens();
    // a* followed by any-byte star
    load_pattern(64'h0000_0000_0000_0061, 64'h0, 16'h0002, 16'h0003, 5'd2);
    send_char(8'h00, 1'b0, 1'b1);
    send_char("a", 1'b0, 1'b0);
    send_char("a", 1'b0, 1'b0);
    send_char("b", 1'b1, 1'b0);
    // a* then literal b
    load_pattern(64'h0000_0000_0000_6261, 64'h0, 16'h0000, 16'h0001, 5'd2);
    send_char("b", 1'b1, 1'b0);
    send_char("a", 1'b0, 1'b0);
    send_char("c", 1'b1, 1'b0);
  endtask

  // All-ones registers; oversize length saturates to the slot count
  task automatic test_full_length();
    load_pattern('1, '1, 16'h0000, 16'hFFFF, 5'd31);
    send_char(8'h00, 1'b1, 1'b1);
    send_char(8'hFF, 1'b0, 1'b0);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'h00, 1'b1, 1'b0);
  endtask

  // Tokens past the length carry junk that must not matter
  task automatic test_unused_tokens();
    load_pattern(64'hFFFF_FFFF_FFFF_FF61, 64'($urandom()) << 32 | 64'($urandom()),
                 16'hFFFE, 16'hFFFE, 5'd1);
    send_char("a", 1'b1, 1'b0);
    send_char("a", 1'b0, 1'b0);
    send_char("b", 1'b1, 1'b0);
  endtask

  // Shrink the length while a string is open
  task automatic test_mid_string_config();
    load_pattern(64'h0000_0000_0063_6261, 64'h0, 16'h0000, 16'h0000, 5'd3);
    send_char("a", 1'b0, 1'b0);
    wait_drain();
    write_reg(REG_PAT_LEN, CFG_DATA_W'(1));
    send_char(8'h00, 1'b0, 1'b1);
    wait_drain();
    write_reg(REG_PAT_LEN, CFG_DATA_W'(3));
    send_char("a", 1'b0, 1'b0);
    send_char("b", 1'b0, 1'b0);
    wait_drain();
    write_reg(REG_PAT_LEN, CFG_DATA_W'(1));
    send_char(8'h00, 1'b0, 1'b1);
  endtask

  // Mostly well-formed strings, with reloads of random patterns between them
  task automatic test_random_traffic(input int unsigned in_pct, input int unsigned out_pct,
                                     input int unsigned target);
    wait_drain();
    in_idle_pct   = in_pct;
    out_stall_pct = out_pct;
    while (items_sent < target) begin
      if ($urandom_range(2) == 0) load_random_pattern();
      send_string($urandom_range(9) < 7);
    end
  endtask

  initial begin
    #4_000_000;
    $display("dot_star_pattern_matcher verification failed");
    $finish;
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = REG_CHARS_LO;
    cfg_data           = '0;
    item_if.valid      = 1'b0;
    item_if.ch         = '0;
    item_if.last       = 1'b0;
    item_if.end_only   = 1'b0;
    result_if.ready    = 1'b0;
    chars_lo_m         = '0;
    chars_hi_m         = '0;
    dot_m              = '0;
    star_m             = '0;
    len_m              = '0;
    nfa_active         = pos_vec_t'(1);
    error_count        = 0;
    items_sent         = 0;
    in_idle_pct        = 0;
    out_stall_pct      = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_pattern();
    test_literal_tokens();
    test_star_tokens();
    test_full_length();
    test_unused_tokens();
    test_mid_string_config();
    test_random_traffic(0, 0, 190);
    test_random_traffic(76, 0, 340);
    test_random_traffic(0, 76, 490);
    test_random_traffic(23, 23, 650);

    wait_drain();
    repeat (8) @(posedge clk);
    if (error_count == 0) begin
      $display("dot_star_pattern_matcher verification clean");
    end else begin
      $display("dot_star_pattern_matcher verification failed");
    end
    $finish;
  end

endmodule
